// ----- hdl/smhr_pkg.sv -----
// Shared types and constants for the SiPM microcell hit register.
// Holds the transaction structs, action, status and register codes, and the
// command/status structs between controller and datapath. No dependencies.
package smhr_pkg;

  // Default sizes of the storage
  localparam int DEF_NUM_SENSORS   = 16;
  localparam int DEF_MAX_TIME_BINS = 32;
  localparam int DEF_MAX_PIX_X     = 16;
  localparam int DEF_MAX_PIX_Y     = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_RESOLVED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_BINS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_BINS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_Y      = 3'd4;

  // Register values after reset
  localparam logic       RST_TIME_RESOLVED = 1'b0;
  localparam logic [5:0] RST_TIME_BINS     = 6'd1;
  localparam logic [5:0] RST_RECOVERY_BINS = 6'd1;
  localparam logic [4:0] RST_PIXELS_X      = 5'd16;
  localparam logic [4:0] RST_PIXELS_Y      = 5'd16;

  // Action codes; the remaining code is a no-op
  localparam logic [1:0] ACT_HIT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Result status codes
  localparam logic STS_OK        = 1'b0;
  localparam logic STS_BIN_RANGE = 1'b1;

  // Saturation limits
  localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [15:0] BIN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] sensor;
    logic [4:0] time_bin;
    logic [3:0] pix_col;
    logic [3:0] pix_row;
    logic [3:0] hit_weight;
  } smhr_in_t;

  typedef struct packed {
    logic [5:0]  newly_lit;
    logic [19:0] sensor_total;
    logic [15:0] bin_count;
    logic        status;
  } smhr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic fetch;
    logic step;
    logic commit;
    logic sweep;
    logic res_load;
  } smhr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] act;
    logic       sens_ok;
    logic       oor;
    logic       last_step;
    logic       sweep_last;
  } smhr_sts_t;

endpackage

// ----- hdl/smhr_datapath.sv -----
// Datapath of the SiPM microcell hit register: configuration registers,
// item registers, lit-mask / total / per-bin memories and the result register.
// Depends on smhr_pkg; sequenced by smhr_ctrl.
module smhr_datapath #(
  parameter int NUM_SENSORS   = smhr_pkg::DEF_NUM_SENSORS,
  parameter int MAX_TIME_BINS = smhr_pkg::DEF_MAX_TIME_BINS,
  parameter int MAX_PIX_X     = smhr_pkg::DEF_MAX_PIX_X,
  parameter int MAX_PIX_Y     = smhr_pkg::DEF_MAX_PIX_Y
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [smhr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smhr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  smhr_pkg::smhr_in_t                  in_data,
  input  smhr_pkg::smhr_cmd_t                 cmd,
  output smhr_pkg::smhr_sts_t                 sts,
  output smhr_pkg::smhr_out_t                 out_data
);
  import smhr_pkg::*;

  localparam int SENS_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int BIN_W   = (MAX_TIME_BINS > 1) ? $clog2(MAX_TIME_BINS) : 1;
  localparam int COL_W   = (MAX_PIX_X > 1) ? $clog2(MAX_PIX_X) : 1;
  localparam int ROW_W   = (MAX_PIX_Y > 1) ? $clog2(MAX_PIX_Y) : 1;
  localparam int CNT_W   = $clog2(MAX_TIME_BINS + 1);
  localparam int PX_W    = $clog2(MAX_PIX_X + 1);
  localparam int PY_W    = $clog2(MAX_PIX_Y + 1);
  localparam int LIT_AW  = SENS_W + ROW_W + COL_W;
  localparam int PB_AW   = SENS_W + BIN_W;
  localparam int SWP_W   = (LIT_AW > PB_AW) ? LIT_AW : PB_AW;
  localparam int LIT_DEPTH = 1 << LIT_AW;
  localparam int PB_DEPTH  = 1 << PB_AW;
  localparam int TOT_DEPTH = 1 << SENS_W;
  localparam logic [MAX_TIME_BINS-1:0] ONE_BIT = MAX_TIME_BINS'(1);

  // Configuration registers
  logic       tres_r;
  logic [5:0] tbins_r;
  logic [5:0] rec_r;
  logic [4:0] pxs_r;
  logic [4:0] pys_r;

  // Item registers
  logic [1:0]        act_r;
  logic [SENS_W-1:0] sens_r;
  logic              sens_ok_r;
  logic              oor_r;
  logic [BIN_W-1:0]  tbin_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [3:0]        wt_r;
  logic [CNT_W-1:0]  left_r;

  // Hit working registers
  logic [BIN_W-1:0]         bin_r;
  logic                     first_r;
  logic [MAX_TIME_BINS-1:0] mask_r;
  logic [19:0]              tot_r;
  logic [CNT_W-1:0]         newly_r;
  logic [15:0]              bcount_r;
  logic [SWP_W-1:0]         swp_r;
  smhr_out_t                out_r;

  // Memories and their read registers
  logic [MAX_TIME_BINS-1:0] lit_mem [LIT_DEPTH];
  logic [19:0]              tot_mem [TOT_DEPTH];
  logic [15:0]              pb_mem  [PB_DEPTH];
  logic [MAX_TIME_BINS-1:0] lit_rd_r;
  logic [19:0]              tot_rd_r;
  logic [15:0]              pb_rd_r;

  // Decoded item values
  logic [CNT_W-1:0] nbins;
  logic [PX_W-1:0]  px;
  logic [PY_W-1:0]  py;
  logic [5:0]       rec_eff;
  logic [4:0]       tbin_eff;
  logic             oor;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] span;
  logic [COL_W-1:0] colc;
  logic [ROW_W-1:0] rowc;
  logic             sens_ok;

  // Step values
  logic [MAX_TIME_BINS-1:0] mask_cur;
  logic [19:0]              tot_cur;
  logic                     bit_new;
  logic [MAX_TIME_BINS-1:0] mask_nxt;
  logic [20:0]              tot_sum;
  logic [19:0]              tot_nxt;
  logic [16:0]              pb_sum;
  logic [15:0]              pb_new;
  logic [15:0]              bcount_nxt;
  logic [BIN_W-1:0]         bin_inc;
  logic [LIT_AW-1:0]        lit_addr;
  logic [PB_AW-1:0]         pb_raddr;
  logic                     pb_we;
  smhr_out_t                res_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tres_r  <= RST_TIME_RESOLVED;
      tbins_r <= RST_TIME_BINS;
      rec_r   <= RST_RECOVERY_BINS;
      pxs_r   <= RST_PIXELS_X;
      pys_r   <= RST_PIXELS_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_RESOLVED: tres_r  <= cfg_wdata[0];
        CFG_TIME_BINS:     tbins_r <= cfg_wdata[5:0];
        CFG_RECOVERY_BINS: rec_r   <= cfg_wdata[5:0];
        CFG_PIXELS_X:      pxs_r   <= cfg_wdata[4:0];
        CFG_PIXELS_Y:      pys_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Clamp register values and decode the incoming transaction
  always_comb begin
    if (!tres_r || tbins_r == '0) begin
      nbins = CNT_W'(1);
    end else if (int'(tbins_r) > MAX_TIME_BINS) begin
      nbins = CNT_W'(MAX_TIME_BINS);
    end else begin
      nbins = CNT_W'(tbins_r);
    end
    if (pxs_r == '0) begin
      px = PX_W'(1);
    end else if (int'(pxs_r) > MAX_PIX_X) begin
      px = PX_W'(MAX_PIX_X);
    end else begin
      px = PX_W'(pxs_r);
    end
    if (pys_r == '0) begin
      py = PY_W'(1);
    end else if (int'(pys_r) > MAX_PIX_Y) begin
      py = PY_W'(MAX_PIX_Y);
    end else begin
      py = PY_W'(pys_r);
    end
    rec_eff  = (rec_r == '0) ? 6'd1 : rec_r;
    tbin_eff = tres_r ? in_data.time_bin : 5'd0;
    oor      = int'(tbin_eff) >= int'(nbins);
    room     = nbins - CNT_W'(tbin_eff);
    span     = (int'(rec_eff) < int'(room)) ? CNT_W'(rec_eff) : room;
    colc     = (int'(in_data.pix_col) >= int'(px)) ? COL_W'(px - PX_W'(1))
                                                   : COL_W'(in_data.pix_col);
    rowc     = (int'(in_data.pix_row) >= int'(py)) ? ROW_W'(py - PY_W'(1))
                                                   : ROW_W'(in_data.pix_row);
    sens_ok  = int'(in_data.sensor) < NUM_SENSORS;
  end

  // Test and light one bin; saturate the counters
  always_comb begin
    mask_cur   = first_r ? lit_rd_r : mask_r;
    tot_cur    = first_r ? tot_rd_r : tot_r;
    bit_new    = !mask_cur[bin_r];
    mask_nxt   = mask_cur | (ONE_BIT << bin_r);
    tot_sum    = {1'b0, tot_cur} + 21'(wt_r);
    tot_nxt    = !bit_new ? tot_cur : (tot_sum[20] ? TOTAL_MAX : tot_sum[19:0]);
    pb_sum     = {1'b0, pb_rd_r} + 17'(wt_r);
    pb_new     = pb_sum[16] ? BIN_MAX : pb_sum[15:0];
    bcount_nxt = (bit_new && tres_r) ? pb_new : pb_rd_r;
    bin_inc    = bin_r + BIN_W'(1);
    lit_addr   = {sens_r, row_r, col_r};
    pb_raddr   = {sens_r, (cmd.fetch ? tbin_r : bin_inc)};
    pb_we      = cmd.step && bit_new && tres_r;
  end

  // Latch the transaction and advance the bin loop
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_data.action;
      sens_r    <= SENS_W'(in_data.sensor);
      sens_ok_r <= sens_ok;
      oor_r     <= oor;
      tbin_r    <= BIN_W'(tbin_eff);
      col_r     <= colc;
      row_r     <= rowc;
      wt_r      <= in_data.hit_weight;
      left_r    <= span;
      bin_r     <= BIN_W'(tbin_eff);
      first_r   <= 1'b1;
      newly_r   <= '0;
    end else if (cmd.step) begin
      left_r    <= left_r - CNT_W'(1);
      bin_r     <= bin_inc;
      first_r   <= 1'b0;
      mask_r    <= mask_nxt;
      tot_r     <= tot_nxt;
      newly_r   <= newly_r + CNT_W'(bit_new);
      if (first_r) begin
        bcount_r <= bcount_nxt;
      end
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r <= '0;
    end else if (cmd.sweep) begin
      swp_r <= swp_r + SWP_W'(1);
    end
  end

  // Lit-mask memory
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      lit_mem[swp_r[LIT_AW-1:0]] <= '0;
    end else if (cmd.commit) begin
      lit_mem[lit_addr] <= mask_r;
    end
    if (cmd.fetch) begin
      lit_rd_r <= lit_mem[lit_addr];
    end
  end

  // Sensor total memory
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      tot_mem[swp_r[SENS_W-1:0]] <= '0;
    end else if (cmd.commit) begin
      tot_mem[sens_r] <= tot_r;
    end
    if (cmd.fetch) begin
      tot_rd_r <= tot_mem[sens_r];
    end
  end

  // Per-bin counter memory: read one bin ahead of the one being written
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      pb_mem[swp_r[PB_AW-1:0]] <= '0;
    end else if (pb_we) begin
      pb_mem[{sens_r, bin_r}] <= pb_new;
    end
    if (cmd.fetch || cmd.step) begin
      pb_rd_r <= pb_mem[pb_raddr];
    end
  end

  // Form the result
  always_comb begin
    res_nxt = '0;
    if (sens_ok_r) begin
      case (act_r)
        ACT_HIT: begin
          if (oor_r) begin
            res_nxt.sensor_total = tot_rd_r;
            res_nxt.status       = STS_BIN_RANGE;
          end else begin
            res_nxt.newly_lit    = 6'(newly_r);
            res_nxt.sensor_total = tot_r;
            res_nxt.bin_count    = bcount_r;
          end
        end
        ACT_READ: begin
          res_nxt.sensor_total = tot_rd_r;
          if (oor_r) begin
            res_nxt.status = STS_BIN_RANGE;
          end else begin
            res_nxt.bin_count = pb_rd_r;
          end
        end
        default: res_nxt = '0;
      endcase
    end
  end

  // Hold the result until the controller loads the next one
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r <= res_nxt;
    end
  end

  assign out_data       = out_r;
  assign sts.act        = act_r;
  assign sts.sens_ok    = sens_ok_r;
  assign sts.oor        = oor_r;
  assign sts.last_step  = (left_r == CNT_W'(1));
  assign sts.sweep_last = &swp_r;

`ifndef SYNTH
  a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> left_r != '0)
    else $error("bin step issued with no bins left");
  a_step_only_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> act_r == ACT_HIT && sens_ok_r && !oor_r)
    else $error("bin step issued for a transaction that is not a valid hit");
  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> left_r == '0 && !first_r)
    else $error("lit mask committed before the bin loop finished");
`endif

endmodule

// ----- hdl/smhr_ctrl.sv -----
// Controller of the SiPM microcell hit register: sequences fetch, bin loop,
// commit, clearing sweep and the result handshake. Depends on smhr_pkg.
module smhr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  smhr_pkg::smhr_sts_t sts,
  output smhr_pkg::smhr_cmd_t cmd
);
  import smhr_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_FETCH,
    S_BINS,
    S_COMMIT,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.fetch    = (state_r == S_FETCH);
    cmd.step     = (state_r == S_BINS);
    cmd.commit   = (state_r == S_COMMIT);
    cmd.sweep    = (state_r == S_SWEEP) || (state_r == S_CLEAR);
    cmd.res_load = (state_r == S_DONE) && out_free;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Advance the sequence; hold the result valid until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          if (sts.sweep_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (sts.act == ACT_CLEAR) begin
            state_r <= S_CLEAR;
          end else if (sts.act == ACT_HIT && sts.sens_ok && !sts.oor) begin
            state_r <= S_BINS;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_BINS: begin
          if (sts.last_step) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: state_r <= S_DONE;
        S_CLEAR: begin
          if (sts.sweep_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_SWEEP;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_FETCH)
    else $error("accepted transaction not followed by fetch");
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> $past(state_r) == S_FETCH || $past(state_r) == S_BINS)
    else $error("bin step outside the hit sequence");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the done state");
`endif

endmodule

// ----- hdl/sipm_microcell_hit_register_unit.sv -----
// Top level of the SiPM microcell hit register.
// Instantiates smhr_ctrl and smhr_datapath; depends on smhr_pkg.
//
// One transaction is taken at a time. A hit passes from acceptance
// through a fetch state, a bin loop over span bins, where span is the
// number of bins tested (at most recovery_bins), doing the
// read-modify-write of each bin's counter in the per-bin memory, a
// commit that writes back the lit mask and sensor total, and the result
// load. A read, an out-of-range bin or sensor, and the unused action go
// from the fetch state straight to the result load. After reset, and on
// every clear action, a sweep zeroes all memories one entry per cycle
// over 2**max(lit-mask address bits, per-bin address bits) addresses
// (4096 at the default size) while no transaction is accepted. A
// transaction that reaches its result load while the previous result is
// still untaken waits until that result is taken. Write configuration
// only while no transaction is in flight. The result register lets the
// next transaction start while the previous result waits to be taken.
module sipm_microcell_hit_register_unit #(
  parameter int NUM_SENSORS   = smhr_pkg::DEF_NUM_SENSORS,
  parameter int MAX_TIME_BINS = smhr_pkg::DEF_MAX_TIME_BINS,
  parameter int MAX_PIX_X     = smhr_pkg::DEF_MAX_PIX_X,
  parameter int MAX_PIX_Y     = smhr_pkg::DEF_MAX_PIX_Y
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [smhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smhr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  smhr_pkg::smhr_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output smhr_pkg::smhr_out_t             out_data
);
  import smhr_pkg::*;

  smhr_cmd_t cmd;
  smhr_sts_t sts;

  // Sequence control
  smhr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  smhr_datapath #(
    .NUM_SENSORS   (NUM_SENSORS),
    .MAX_TIME_BINS (MAX_TIME_BINS),
    .MAX_PIX_X     (MAX_PIX_X),
    .MAX_PIX_Y     (MAX_PIX_Y)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
